// ----- hdl/tccw_pkg.sv -----
// shared types, constants and helpers for the text console character writer
// no dependencies
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELLS);

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COLUMN_FW = 7;
  localparam int ROW_FW    = 5;
  localparam int CURSOR_FW = 11;
  localparam int CELL_DW   = CHAR_W + ATTR_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELDS_W = CHAR_W + CURSOR_FW + CHAR_W + ATTR_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    WD_INIT,
    WD_BLANK,
    WD_CHAR,
    WD_COPY
  } wdata_sel_e;

  typedef enum logic [1:0] {
    WA_CNT,
    WA_CNT_PREV,
    WA_TARGET
  } waddr_sel_e;

  typedef enum logic {
    RA_AHEAD,
    RA_TARGET
  } raddr_sel_e;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_BS,
    KIND_NL,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic       req_load;
    logic       cnt_clear;
    logic       cnt_inc;
    logic       mem_we;
    wdata_sel_e wd_sel;
    waddr_sel_e wa_sel;
    logic       mem_re;
    raddr_sel_e ra_sel;
    logic       cursor_upd;
    logic       out_load;
    logic       res_clear;
    logic       res_inc;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scroll_need;
    logic  cnt_zero;
    logic  copy_end;
    logic  cnt_end;
    logic  out_free;
    logic  res_last;
  } status_t;

  typedef struct packed {
    logic [ATTR_W-1:0]    cell_attr;
    logic [CHAR_W-1:0]    cell_char;
    logic [CURSOR_FW-1:0] cursor_cell;
    logic [CHAR_W-1:0]    serial_byte;
  } result_t;

  function automatic logic [CELL_W-1:0] cell_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return CELL_W'(r) * CELL_W'(COLUMNS) + CELL_W'(c);
  endfunction

endpackage

// ----- hdl/text_console_char_writer_top.sv -----
// top level of the text console character writer
// depends on tccw_pkg, tccw_ctrl, tccw_datapath
`timescale 1ns / 1ps

// Text console engine keeping an 80 x 25 store of character/attribute cells and a cursor.
// Input stream: tuser is the opcode (0 print, 1 read cell), tdata carries the character,
// the use-position flag and the column and row. Output stream gives one result per echo
// byte of a print (one, two or three, the final one with tlast) or one result per read.
// cfg_we_i writes the attribute byte stored with every printed or blanked cell; write it
// only while no request is in flight.
// One request is handled at a time. A plain print or a read goes through accept, one
// screen store access and one result load; a newline or a backspace adds one result load
// per further echo byte. A request that scrolls copies 1920 cells and blanks 80, one cell
// per cycle, before its results.
// The next request is taken while the last result still waits in the output register.
// After reset a pass over all 2000 cells clears the store to spaces with attribute 07;
// tready stays low until it ends. If the receiver stalls, the result holds in the output
// register and the engine waits in its emit state.

module text_console_char_writer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // char_code[7:0], use_position[8], column[15:9], row_index[20:16]
  input  logic [tccw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // serial_byte[7:0], cursor_cell[18:8], cell_char[26:19], cell_attr[34:27]
  output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import tccw_pkg::*;

  cmd_t    cmd;
  status_t sts;

  tccw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tccw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ----- hdl/tccw_ctrl.sv -----
// controller state machine: clearing pass, request sequencing, scroll walk, result emission
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  tccw_pkg::status_t sts_i,
  output tccw_pkg::cmd_t    cmd_o
);
  import tccw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.cnt_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.kind != KIND_READ && sts_i.scroll_need) state_d = ST_COPY;
        else state_d = ST_EMIT;
      end
      ST_COPY: begin
        if (sts_i.copy_end) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (sts_i.cnt_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.res_last) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_INIT;
        cmd_o.wa_sel = WA_CNT;
        if (sts_i.cnt_end) cmd_o.cnt_clear = 1'b1;
        else cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        cmd_o.req_load = s_axis_tvalid;
      end
      ST_EXEC: begin
        cmd_o.wa_sel = WA_TARGET;
        cmd_o.ra_sel = RA_TARGET;
        case (sts_i.kind)
          KIND_READ: cmd_o.mem_re = 1'b1;
          KIND_BS: begin
            cmd_o.mem_we     = 1'b1;
            cmd_o.wd_sel     = WD_BLANK;
            cmd_o.cursor_upd = 1'b1;
          end
          KIND_NL: cmd_o.cursor_upd = 1'b1;
          KIND_CHAR: begin
            cmd_o.mem_we     = 1'b1;
            cmd_o.wd_sel     = WD_CHAR;
            cmd_o.cursor_upd = 1'b1;
          end
          default: cmd_o.cursor_upd = 1'b0;
        endcase
      end
      ST_COPY: begin
        cmd_o.wd_sel = WD_COPY;
        cmd_o.wa_sel = WA_CNT_PREV;
        cmd_o.ra_sel = RA_AHEAD;
        if (sts_i.copy_end) begin
          cmd_o.mem_we = 1'b1;
        end else begin
          cmd_o.mem_we  = !sts_i.cnt_zero;
          cmd_o.mem_re  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_BLANK: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = WD_BLANK;
        cmd_o.wa_sel = WA_CNT;
        if (sts_i.cnt_end) cmd_o.cnt_clear = 1'b1;
        else cmd_o.cnt_inc = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.res_last) cmd_o.res_clear = 1'b1;
          else cmd_o.res_inc = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/tccw_datapath.sv -----
// datapath: screen store, cursor, attribute register, walk counter and output register
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tuser,
  input  logic [tccw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [tccw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  input  tccw_pkg::cmd_t                      cmd_i,
  output tccw_pkg::status_t                   sts_o
);
  import tccw_pkg::*;

  logic [CELL_DW-1:0] mem [CELLS];
  logic [CELL_DW-1:0] rdata_q;

  logic [ATTR_W-1:0] attr_q;
  kind_e             kind_q;
  logic [CHAR_W-1:0] char_q;
  logic              usepos_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [CELL_W-1:0] cnt_q;
  logic [1:0]        res_q;
  result_t           out_q;
  logic              out_valid_q;
  logic              out_last_q;

  logic [CHAR_W-1:0]    in_char;
  logic [COLUMN_FW-1:0] in_col;
  logic [ROW_FW-1:0]    in_row;
  logic [COL_W-1:0]     in_col_clamp;
  logic [ROW_W-1:0]     in_row_clamp;
  kind_e                in_kind;

  logic [COL_W-1:0]  tgt_col, bs_col, nxt_col;
  logic [ROW_W-1:0]  tgt_row, bs_row, nxt_row;
  logic              col_last, row_last;
  logic [CELL_W-1:0] waddr, raddr;
  logic [CELL_DW-1:0] wdata;
  logic [CHAR_W-1:0] serial;
  result_t           res_d;

  // request fields
  assign in_char = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[15:9];
  assign in_row  = s_axis_tdata[20:16];

  always_comb begin
    if (int'(in_col) > COLUMNS - 1) in_col_clamp = COL_W'(COLUMNS - 1);
    else in_col_clamp = COL_W'(in_col);
    if (int'(in_row) > ROWS - 1) in_row_clamp = ROW_W'(ROWS - 1);
    else in_row_clamp = ROW_W'(in_row);
    if (s_axis_tuser) in_kind = KIND_READ;
    else if (in_char == CH_BACKSPACE) in_kind = KIND_BS;
    else if (in_char == CH_NEWLINE) in_kind = KIND_NL;
    else in_kind = KIND_CHAR;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q   <= in_kind;
      char_q   <= in_char;
      usepos_q <= s_axis_tdata[8];
      col_q    <= in_col_clamp;
      row_q    <= in_row_clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // target cell and cursor moves
  always_comb begin
    if (usepos_q || kind_q == KIND_READ) begin
      tgt_col = col_q;
      tgt_row = row_q;
    end else begin
      tgt_col = cur_col_q;
      tgt_row = cur_row_q;
    end
    col_last = (tgt_col == COL_W'(COLUMNS - 1));
    row_last = (tgt_row == ROW_W'(ROWS - 1));

    bs_col = tgt_col;
    bs_row = tgt_row;
    if (tgt_col != '0) begin
      bs_col = tgt_col - COL_W'(1);
    end else if (tgt_row != '0) begin
      bs_col = COL_W'(COLUMNS - 1);
      bs_row = tgt_row - ROW_W'(1);
    end

    nxt_col = tgt_col;
    nxt_row = tgt_row;
    case (kind_q)
      KIND_BS: begin
        nxt_col = bs_col;
        nxt_row = bs_row;
      end
      KIND_NL: begin
        nxt_col = '0;
        if (!row_last) nxt_row = tgt_row + ROW_W'(1);
      end
      KIND_CHAR: begin
        if (col_last) begin
          nxt_col = '0;
          if (!row_last) nxt_row = tgt_row + ROW_W'(1);
        end else begin
          nxt_col = tgt_col + COL_W'(1);
        end
      end
      default: nxt_col = tgt_col;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else if (cmd_i.cursor_upd) begin
      cur_col_q <= nxt_col;
      cur_row_q <= nxt_row;
    end
  end

  // walk counter for clearing and scrolling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CELL_W'(1);
    end
  end

  // screen store
  always_comb begin
    case (cmd_i.wa_sel)
      WA_CNT:      waddr = cnt_q;
      WA_CNT_PREV: waddr = cnt_q - CELL_W'(1);
      WA_TARGET: begin
        if (kind_q == KIND_BS) waddr = cell_of(bs_row, bs_col);
        else waddr = cell_of(tgt_row, tgt_col);
      end
      default:     waddr = cnt_q;
    endcase
    case (cmd_i.wd_sel)
      WD_INIT:  wdata = {RESET_ATTR, BLANK_CHAR};
      WD_BLANK: wdata = {attr_q, BLANK_CHAR};
      WD_CHAR:  wdata = {attr_q, char_q};
      WD_COPY:  wdata = rdata_q;
      default:  wdata = {attr_q, BLANK_CHAR};
    endcase
    if (cmd_i.ra_sel == RA_AHEAD) raddr = cnt_q + CELL_W'(COLUMNS);
    else raddr = cell_of(tgt_row, tgt_col);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[waddr] <= wdata;
    if (cmd_i.mem_re) rdata_q <= mem[raddr];
  end

  // result sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.res_clear) begin
      res_q <= '0;
    end else if (cmd_i.res_inc) begin
      res_q <= res_q + 2'd1;
    end
  end

  always_comb begin
    case (kind_q)
      KIND_BS:   serial = (res_q == 2'd1) ? BLANK_CHAR : CH_BACKSPACE;
      KIND_NL:   serial = (res_q == 2'd0) ? CH_RETURN : CH_NEWLINE;
      KIND_CHAR: serial = char_q;
      default:   serial = '0;
    endcase
    res_d.serial_byte = serial;
    res_d.cursor_cell = CURSOR_FW'(cell_of(cur_row_q, cur_col_q));
    if (kind_q == KIND_READ) begin
      res_d.cell_char = rdata_q[CHAR_W-1:0];
      res_d.cell_attr = rdata_q[CELL_DW-1:CHAR_W];
    end else begin
      res_d.cell_char = '0;
      res_d.cell_attr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q      <= res_d;
      out_last_q <= sts_o.res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    sts_o.kind        = kind_q;
    sts_o.scroll_need = (kind_q == KIND_NL && row_last) ||
                        (kind_q == KIND_CHAR && row_last && col_last);
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.copy_end    = (cnt_q == CELL_W'(CELLS - COLUMNS));
    sts_o.cnt_end     = (cnt_q == CELL_W'(CELLS - 1));
    sts_o.out_free    = !out_valid_q || m_axis_tready;
    case (kind_q)
      KIND_BS: sts_o.res_last = (res_q == 2'd2);
      KIND_NL: sts_o.res_last = (res_q == 2'd1);
      default: sts_o.res_last = (res_q == 2'd0);
    endcase
  end

endmodule

// ----- hdl/tccw_checker.sv -----
// port-level checks for the text console character writer, bound to the top level
// depends on tccw_pkg and text_console_char_writer_top
`timescale 1ns / 1ps

module tccw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import tccw_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken back to back");

  // no new request while a result run is unfinished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken in the middle of a result run");

  // cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:8] < CURSOR_FW'(CELLS))
    else $error("cursor cell out of range");

  // echo results carry no cell contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:0] != 8'h00 |-> m_axis_tdata[34:19] == 16'h0000)
    else $error("print result carries cell data");

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (.*);
